// ===== rtl/tdp_pkg.sv =====
package tdp_pkg;

  typedef enum logic [3:0] {
    PH_LEAD   = 4'd0,
    PH_FIRST  = 4'd1,
    PH_COLON  = 4'd2,
    PH_MIN    = 4'd3,
    PH_TRAIL  = 4'd4,
    PH_SUFFIX = 4'd5,
    PH_DONE   = 4'd6
  } phase_t;

  localparam logic [3:0] ERR_OK          = 4'd0;
  localparam logic [3:0] ERR_EMPTY       = 4'd1;
  localparam logic [3:0] ERR_HOURS_START = 4'd2;
  localparam logic [3:0] ERR_LAYOUT      = 4'd3;
  localparam logic [3:0] ERR_MIN_START   = 4'd4;
  localparam logic [3:0] ERR_MIN_RANGE   = 4'd5;
  localparam logic [3:0] ERR_HOURS_RANGE = 4'd6;
  localparam logic [3:0] ERR_HOURS_12H   = 4'd7;
  localparam logic [3:0] ERR_SUFFIX      = 4'd8;

  localparam logic [1:0] SUF_NONE = 2'd0;
  localparam logic [1:0] SUF_AM   = 2'd1;
  localparam logic [1:0] SUF_PM   = 2'd2;

  localparam logic [13:0] FIRST_MAX  = 14'd16383;
  localparam logic [2:0]  COUNT_MAX  = 3'd7;
  localparam logic [6:0]  MINUTE_MAX = 7'd127;

  localparam logic [16:0] SECONDS_MAX = 17'd86340;

  typedef struct packed {
    phase_t      phase;
    logic [13:0] first_number;
    logic [2:0]  digit_count;
    logic [6:0]  minute_number;
    logic [3:0]  latched_error;
    logic [1:0]  suffix_letter;
  } parse_state_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] error_code;
    logic [4:0] hours;
    logic [5:0] minutes;
  } step_result_t;

  localparam parse_state_t PARSE_CLEAR = '{
    phase:         PH_LEAD,
    first_number:  14'd0,
    digit_count:   3'd0,
    minute_number: 7'd0,
    latched_error: ERR_OK,
    suffix_letter: SUF_NONE
  };

endpackage

// ===== rtl/time_of_day_text_parser.sv =====
// Clock-time text parser: feed one ASCII byte per transaction; each string
// (ended by a NUL byte or a byte with last_char set) yields one result with
// an error code and the seconds since midnight. A byte is captured in an
// input register at its accepting edge and advanced through the parse state
// at the edge on which the stage advances, which also loads its result, if
// any, into the output register that drives out_valid. The parse state
// loop is closed by combinational step logic, giving a sustained rate of
// one byte per cycle; input stalls only while a result waits in the output
// register and the next byte would produce another one.
module time_of_day_text_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        last_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  error_code,
  output logic [16:0] seconds_of_day
);
  import tdp_pkg::*;

  logic         in_full;
  logic [7:0]   in_char;
  logic         in_last;
  parse_state_t state;
  parse_state_t state_next;
  logic         string_ended;
  logic         string_ended_next;
  step_result_t step_res;
  logic         stage_go;
  logic [4:0]   res_hours;
  logic [5:0]   res_minutes;

  tdp_step u_step (
    .state             (state),
    .string_ended      (string_ended),
    .char_code         (in_char),
    .last_char         (in_last),
    .state_next        (state_next),
    .string_ended_next (string_ended_next),
    .result            (step_res)
  );

  // Advance unless a new result would overwrite one still waiting.
  assign stage_go = in_full && (!step_res.valid || !out_valid || out_ready);
  assign in_ready = !in_full || stage_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_char <= char_code;
      in_last <= last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= PARSE_CLEAR;
      string_ended <= 1'b0;
    end else if (stage_go) begin
      state        <= state_next;
      string_ended <= string_ended_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_go && step_res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go && step_res.valid) begin
      error_code  <= step_res.error_code;
      res_hours   <= step_res.hours;
      res_minutes <= step_res.minutes;
    end
  end

  assign seconds_of_day = (error_code == ERR_OK)
                        ? ({12'd0, res_hours} * 17'd3600 + {11'd0, res_minutes} * 17'd60)
                        : 17'd0;

`ifndef SYNTHESIS
  a_ok_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (error_code == ERR_OK) |-> seconds_of_day <= SECONDS_MAX)
    else $error("seconds_of_day out of range on ok result");

  a_err_zero_secs: assert property (@(posedge clk) disable iff (rst)
    out_valid && (error_code != ERR_OK) |-> seconds_of_day == 17'd0)
    else $error("nonzero seconds on error result");

  a_err_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> error_code <= ERR_SUFFIX)
    else $error("error code beyond defined set");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_full && !stage_go |=> in_full && $stable(in_char) && $stable(in_last))
    else $error("stalled input byte lost");
`endif

endmodule

// ===== rtl/tdp_step.sv =====
module tdp_step (
  input  tdp_pkg::parse_state_t state,
  input  logic                  string_ended,
  input  logic [7:0]            char_code,
  input  logic                  last_char,
  output tdp_pkg::parse_state_t state_next,
  output logic                  string_ended_next,
  output tdp_pkg::step_result_t result
);
  import tdp_pkg::*;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic parse_state_t finish(input parse_state_t s, input logic [3:0] e);
    parse_state_t r;
    r = s;
    r.latched_error = e;
    r.phase = PH_DONE;
    return r;
  endfunction

  function automatic parse_state_t trail(input parse_state_t s, input logic [7:0] c);
    parse_state_t r;
    r = s;
    if (c == 8'h00) begin
      r = finish(s, ERR_OK);
    end else if (is_ws(c)) begin
      r.phase = PH_TRAIL;
    end else if (c == 8'h41 || c == 8'h61) begin
      r.suffix_letter = SUF_AM;
      r.phase = PH_SUFFIX;
    end else if (c == 8'h50 || c == 8'h70) begin
      r.suffix_letter = SUF_PM;
      r.phase = PH_SUFFIX;
    end else begin
      r = finish(s, ERR_SUFFIX);
    end
    return r;
  endfunction

  // Minutes are checked before hours.
  function automatic parse_state_t check_trail(input parse_state_t s, input logic [7:0] c);
    parse_state_t r;
    if (s.minute_number >= 7'd60) begin
      r = finish(s, ERR_MIN_RANGE);
    end else if (s.first_number > 14'd23) begin
      r = finish(s, ERR_HOURS_RANGE);
    end else begin
      r = trail(s, c);
    end
    return r;
  endfunction

  // Split HHMM: divide by 100 through a reciprocal, exact below 16384.
  function automatic parse_state_t split_hhmm(input parse_state_t s);
    parse_state_t r;
    logic [26:0] prod;
    logic [7:0]  quot;
    logic [13:0] rem;
    r = s;
    prod = {13'd0, s.first_number} * 27'd5243;
    quot = prod[26:19];
    rem = s.first_number - 14'({6'd0, quot} * 14'd100);
    r.first_number = {6'd0, quot};
    r.minute_number = rem[6:0];
    return r;
  endfunction

  function automatic parse_state_t suffix(input parse_state_t s, input logic [7:0] c);
    parse_state_t r;
    logic [13:0] h;
    r = s;
    h = s.first_number;
    if (c != 8'h4d && c != 8'h6d) begin
      r = finish(s, ERR_SUFFIX);
    end else if (h < 14'd1 || h > 14'd12) begin
      r = finish(s, ERR_HOURS_12H);
    end else begin
      if (s.suffix_letter == SUF_AM) begin
        if (h == 14'd12) h = 14'd0;
      end else if (h != 14'd12) begin
        h = h + 14'd12;
      end
      r.first_number = h;
      r = finish(r, ERR_OK);
    end
    return r;
  endfunction

  function automatic parse_state_t feed(input parse_state_t s, input logic [7:0] c);
    parse_state_t r;
    logic [17:0]  fv;
    logic [10:0]  mv;
    r = s;
    fv = {4'd0, s.first_number} * 18'd10 + {14'd0, c[3:0]};
    mv = {4'd0, s.minute_number} * 11'd10 + {7'd0, c[3:0]};
    case (s.phase)
      PH_LEAD: begin
        if (c == 8'h00) begin
          r = finish(s, ERR_EMPTY);
        end else if (is_ws(c)) begin
          r = s;
        end else if (is_dig(c)) begin
          r.first_number = {10'd0, c[3:0]};
          r.digit_count = 3'd1;
          r.phase = PH_FIRST;
        end else begin
          r = finish(s, ERR_HOURS_START);
        end
      end
      PH_FIRST: begin
        if (is_dig(c)) begin
          r.first_number = (fv > {4'd0, FIRST_MAX}) ? FIRST_MAX : fv[13:0];
          if (s.digit_count < COUNT_MAX) r.digit_count = s.digit_count + 3'd1;
        end else if (s.digit_count == 3'd4) begin
          r = check_trail(split_hhmm(s), c);
        end else if (c == 8'h3a) begin
          r.phase = PH_COLON;
        end else if (s.digit_count == 3'd2) begin
          r.minute_number = 7'd0;
          r = check_trail(r, c);
        end else begin
          r = finish(s, ERR_LAYOUT);
        end
      end
      PH_COLON: begin
        if (is_dig(c)) begin
          r.minute_number = {3'd0, c[3:0]};
          r.phase = PH_MIN;
        end else begin
          r = finish(s, ERR_MIN_START);
        end
      end
      PH_MIN: begin
        if (is_dig(c)) begin
          r.minute_number = (mv > {4'd0, MINUTE_MAX}) ? MINUTE_MAX : mv[6:0];
        end else begin
          r = check_trail(s, c);
        end
      end
      PH_TRAIL:  r = trail(s, c);
      PH_SUFFIX: r = suffix(s, c);
      default:   r = s;
    endcase
    return r;
  endfunction

  parse_state_t after_char;
  parse_state_t after_end;
  logic         ends_here;

  assign after_char = feed(state, char_code);
  // A marked nonzero byte is followed by an implied terminator.
  assign after_end  = (char_code != 8'h00) ? feed(after_char, 8'h00) : after_char;
  assign ends_here  = (char_code == 8'h00) || last_char;

  always_comb begin
    state_next        = state;
    string_ended_next = string_ended;
    result            = '0;
    if (string_ended) begin
      // Drop bytes up to and including the next marked one.
      if (last_char) begin
        string_ended_next = 1'b0;
        state_next        = PARSE_CLEAR;
      end
    end else if (!ends_here) begin
      state_next = after_char;
    end else begin
      result.valid      = 1'b1;
      result.error_code = after_end.latched_error;
      result.hours      = after_end.first_number[4:0];
      result.minutes    = after_end.minute_number[5:0];
      state_next        = PARSE_CLEAR;
      string_ended_next = (char_code == 8'h00) && !last_char;
    end
  end

endmodule
